// ----- design/sdnft_pkg.sv -----
// sdnft_pkg: shared types and codes for the flow-table switch
// item, result, packet, configuration, controller command and status types
// no dependencies
package sdnft_pkg;

  localparam int ADDR_W = 5;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] time_now;
    logic [15:0] recipient_addr;
    logic [15:0] src_addr;
    logic [15:0] dst_addr;
    logic [7:0]  ttl;
    logic [15:0] packet_handle;
    logic [1:0]  rule_action;
    logic [15:0] rule_next_hop;
    logic [31:0] rule_idle_timeout;
    logic [31:0] rule_hard_timeout;
    logic [15:0] rule_owner;
  } item_t;

  typedef struct packed {
    logic [4:0]  disposition;
    logic [15:0] out_handle;
    logic [15:0] out_next_hop;
    logic [7:0]  out_ttl;
    logic [15:0] out_dst;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] src;
    logic [15:0] dst;
    logic [7:0]  ttl;
  } pkt_t;

  typedef struct packed {
    logic [15:0] my_id;
    logic [15:0] rsu_prefix;
    logic        is_vehicle;
    logic [4:0]  max_flow_rules;
    logic [4:0]  max_packet_in;
    logic [4:0]  max_standby;
  } cfg_t;

  localparam logic [2:0] REQ_DATA    = 3'd0;
  localparam logic [2:0] REQ_INSTALL = 3'd1;
  localparam logic [2:0] REQ_BEACON  = 3'd2;
  localparam logic [2:0] REQ_CLEAR   = 3'd3;
  localparam logic [2:0] REQ_RELEASE = 3'd4;

  localparam logic [1:0] ACT_FWD     = 2'd0;
  localparam logic [1:0] ACT_STANDBY = 2'd1;
  localparam logic [1:0] ACT_DROP    = 2'd2;
  localparam logic [1:0] ACT_SPECIAL = 2'd3;

  localparam logic [2:0] REG_MY_ID       = 3'd0;
  localparam logic [2:0] REG_RSU_PREFIX  = 3'd1;
  localparam logic [2:0] REG_IS_VEHICLE  = 3'd2;
  localparam logic [2:0] REG_MAX_FLOW    = 3'd3;
  localparam logic [2:0] REG_MAX_PKT_IN  = 3'd4;
  localparam logic [2:0] REG_MAX_STANDBY = 3'd5;

  typedef enum logic [4:0] {
    DISP_IGNORED       = 5'd0,
    DISP_DELIVER       = 5'd1,
    DISP_RADIO_FWD     = 5'd2,
    DISP_WIRED_FWD     = 5'd3,
    DISP_TTL_DROP      = 5'd4,
    DISP_RULE_DROP     = 5'd5,
    DISP_SPECIAL_DROP  = 5'd6,
    DISP_STANDBY       = 5'd7,
    DISP_STANDBY_FULL  = 5'd8,
    DISP_PARKED        = 5'd9,
    DISP_PACKET_IN     = 5'd10,
    DISP_PARK_FULL     = 5'd11,
    DISP_INSTALLED     = 5'd12,
    DISP_TABLE_FULL    = 5'd13,
    DISP_NBR_ADDED     = 5'd14,
    DISP_NBR_KNOWN     = 5'd15,
    DISP_CLEARED       = 5'd16,
    DISP_STANDBY_EMPTY = 5'd17
  } disp_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_R_INIT,
    OP_R_NEXT,
    OP_R_KEEP,
    OP_R_KILL,
    OP_N_INIT,
    OP_N_NEXT,
    OP_HIT,
    OP_SB_PUSH,
    OP_SB_POP,
    OP_K_INIT,
    OP_K_NEXT,
    OP_PK_PUSH,
    OP_INS_STEP,
    OP_INS_WRITE,
    OP_CMP_STEP,
    OP_CMP_END,
    OP_RP_LOAD,
    OP_NBR_ADD,
    OP_NBR_CLR
  } op_t;

  typedef struct packed {
    op_t   op;
    logic  emit;
    disp_t code;
    logic  last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [1:0] r_act;
    logic recip_me;
    logic owner_me;
    logic dst_me;
    logic src_me;
    logic ttl_zero;
    logic r_valid;
    logic r_expired;
    logic r_dest_hit;
    logic r_wired;
    logic r_last;
    logic n_end;
    logic n_hit_hop;
    logic n_hit_src;
    logic nbr_full;
    logic table_full;
    logic park_full;
    logic k_end;
    logic k_hit;
    logic sb_full;
    logic sb_empty;
    logic sel_empty;
    logic sel_done;
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_CL_START,
    S_CL_RULE,
    S_CL_NBR,
    S_DP_HEAD,
    S_DP_MATCH,
    S_DP_ACT,
    S_PK_CHECK,
    S_PK_SCAN,
    S_INS_CHECK,
    S_INS_SCAN,
    S_INS_WRITE,
    S_CMP,
    S_RP_LOAD,
    S_BC_SCAN
  } state_t;

endpackage

// ----- design/sdnft_ctrl.sv -----
// sdnft_ctrl: sequencer for the flow-table switch
// walks cleanup, match, park, install, replay and beacon-scan steps; issues one command a cycle
// depends on sdnft_pkg
module sdnft_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  sdnft_pkg::status_t st,
  output logic               busy,
  output sdnft_pkg::cmd_t    cmd
);

  sdnft_pkg::state_t state, state_next;
  logic mode_install, mode_install_next;
  logic replay, replay_next;
  logic pkt_last;
  sdnft_pkg::state_t after_clean, end_pkt;

  assign busy        = (state != sdnft_pkg::S_IDLE);
  assign pkt_last    = !replay || st.sel_done;
  assign after_clean = mode_install ? sdnft_pkg::S_INS_CHECK : sdnft_pkg::S_DP_HEAD;
  assign end_pkt     = pkt_last ? sdnft_pkg::S_IDLE : sdnft_pkg::S_RP_LOAD;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sdnft_pkg::S_IDLE;
      mode_install <= 1'b0;
      replay       <= 1'b0;
    end else begin
      state        <= state_next;
      mode_install <= mode_install_next;
      replay       <= replay_next;
    end
  end

  // next state
  always_comb begin
    state_next        = state;
    mode_install_next = mode_install;
    replay_next       = replay;
    unique case (state)
      sdnft_pkg::S_IDLE: begin
        replay_next = 1'b0;
        if (start) state_next = sdnft_pkg::S_DISPATCH;
      end
      sdnft_pkg::S_DISPATCH: begin
        mode_install_next = 1'b0;
        priority case (st.req_type)
          sdnft_pkg::REQ_DATA:
            state_next = st.recip_me ? sdnft_pkg::S_CL_START : sdnft_pkg::S_IDLE;
          sdnft_pkg::REQ_INSTALL: begin
            mode_install_next = 1'b1;
            state_next = st.owner_me ? sdnft_pkg::S_CL_START : sdnft_pkg::S_IDLE;
          end
          sdnft_pkg::REQ_BEACON: state_next = sdnft_pkg::S_BC_SCAN;
          sdnft_pkg::REQ_RELEASE:
            state_next = st.sb_empty ? sdnft_pkg::S_IDLE : sdnft_pkg::S_CL_START;
          default: state_next = sdnft_pkg::S_IDLE;
        endcase
      end
      sdnft_pkg::S_CL_START: state_next = sdnft_pkg::S_CL_RULE;
      sdnft_pkg::S_CL_RULE: begin
        if (!st.r_valid || st.r_expired || st.r_act != sdnft_pkg::ACT_FWD) begin
          if (st.r_last) state_next = after_clean;
        end else begin
          state_next = sdnft_pkg::S_CL_NBR;
        end
      end
      sdnft_pkg::S_CL_NBR: begin
        if (st.n_end || st.n_hit_hop)
          state_next = st.r_last ? after_clean : sdnft_pkg::S_CL_RULE;
      end
      sdnft_pkg::S_DP_HEAD: begin
        if (st.dst_me || st.ttl_zero) state_next = end_pkt;
        else state_next = sdnft_pkg::S_DP_MATCH;
      end
      sdnft_pkg::S_DP_MATCH: begin
        if (st.r_valid && st.r_dest_hit) state_next = sdnft_pkg::S_DP_ACT;
        else if (st.r_last) state_next = sdnft_pkg::S_PK_CHECK;
      end
      sdnft_pkg::S_DP_ACT: state_next = end_pkt;
      sdnft_pkg::S_PK_CHECK:
        state_next = st.park_full ? end_pkt : sdnft_pkg::S_PK_SCAN;
      sdnft_pkg::S_PK_SCAN: begin
        if (st.k_end || st.k_hit) state_next = end_pkt;
      end
      sdnft_pkg::S_INS_CHECK:
        state_next = st.table_full ? sdnft_pkg::S_IDLE : sdnft_pkg::S_INS_SCAN;
      sdnft_pkg::S_INS_SCAN: begin
        if (st.r_last) state_next = sdnft_pkg::S_INS_WRITE;
      end
      sdnft_pkg::S_INS_WRITE: state_next = sdnft_pkg::S_CMP;
      sdnft_pkg::S_CMP: begin
        if (st.k_end) begin
          if (st.sel_empty) begin
            state_next = sdnft_pkg::S_IDLE;
          end else begin
            state_next  = sdnft_pkg::S_RP_LOAD;
            replay_next = 1'b1;
          end
        end
      end
      sdnft_pkg::S_RP_LOAD: begin
        mode_install_next = 1'b0;
        state_next = sdnft_pkg::S_CL_START;
      end
      sdnft_pkg::S_BC_SCAN: begin
        if (st.n_end || st.n_hit_src) state_next = sdnft_pkg::S_IDLE;
      end
      default: state_next = sdnft_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '{op: sdnft_pkg::OP_NONE, emit: 1'b0,
                 code: sdnft_pkg::DISP_IGNORED, last: 1'b0};
    cmd.last = pkt_last;
    unique case (state)
      sdnft_pkg::S_IDLE: begin
        if (start) cmd.op = sdnft_pkg::OP_LOAD;
      end
      sdnft_pkg::S_DISPATCH: begin
        cmd.last = 1'b1;
        priority case (st.req_type)
          sdnft_pkg::REQ_DATA: cmd.emit = !st.recip_me;
          sdnft_pkg::REQ_INSTALL: cmd.emit = !st.owner_me;
          sdnft_pkg::REQ_BEACON: cmd.op = sdnft_pkg::OP_N_INIT;
          sdnft_pkg::REQ_CLEAR: begin
            cmd.op   = sdnft_pkg::OP_NBR_CLR;
            cmd.emit = 1'b1;
            cmd.code = sdnft_pkg::DISP_CLEARED;
          end
          sdnft_pkg::REQ_RELEASE: begin
            if (st.sb_empty) begin
              cmd.emit = 1'b1;
              cmd.code = sdnft_pkg::DISP_STANDBY_EMPTY;
            end else begin
              cmd.op = sdnft_pkg::OP_SB_POP;
            end
          end
          default: cmd.emit = 1'b1;
        endcase
      end
      sdnft_pkg::S_CL_START: cmd.op = sdnft_pkg::OP_R_INIT;
      sdnft_pkg::S_CL_RULE: begin
        if (!st.r_valid) cmd.op = sdnft_pkg::OP_R_NEXT;
        else if (st.r_expired) cmd.op = sdnft_pkg::OP_R_KILL;
        else if (st.r_act != sdnft_pkg::ACT_FWD) cmd.op = sdnft_pkg::OP_R_KEEP;
        else cmd.op = sdnft_pkg::OP_N_INIT;
      end
      sdnft_pkg::S_CL_NBR: begin
        if (st.n_end) cmd.op = sdnft_pkg::OP_R_KILL;
        else if (st.n_hit_hop) cmd.op = sdnft_pkg::OP_R_KEEP;
        else cmd.op = sdnft_pkg::OP_N_NEXT;
      end
      sdnft_pkg::S_DP_HEAD: begin
        if (st.dst_me) begin
          cmd.emit = 1'b1;
          cmd.code = sdnft_pkg::DISP_DELIVER;
        end else if (st.ttl_zero) begin
          cmd.emit = 1'b1;
          cmd.code = sdnft_pkg::DISP_TTL_DROP;
        end else begin
          cmd.op = sdnft_pkg::OP_R_INIT;
        end
      end
      sdnft_pkg::S_DP_MATCH: begin
        if (st.r_valid && st.r_dest_hit) cmd.op = sdnft_pkg::OP_HIT;
        else if (!st.r_last) cmd.op = sdnft_pkg::OP_R_NEXT;
      end
      sdnft_pkg::S_DP_ACT: begin
        cmd.emit = 1'b1;
        unique case (st.r_act)
          sdnft_pkg::ACT_SPECIAL, sdnft_pkg::ACT_FWD: begin
            if (st.r_act == sdnft_pkg::ACT_SPECIAL && !st.src_me)
              cmd.code = sdnft_pkg::DISP_SPECIAL_DROP;
            else if (st.r_wired)
              cmd.code = sdnft_pkg::DISP_WIRED_FWD;
            else
              cmd.code = sdnft_pkg::DISP_RADIO_FWD;
          end
          sdnft_pkg::ACT_STANDBY: begin
            if (st.sb_full) begin
              cmd.code = sdnft_pkg::DISP_STANDBY_FULL;
            end else begin
              cmd.op   = sdnft_pkg::OP_SB_PUSH;
              cmd.code = sdnft_pkg::DISP_STANDBY;
            end
          end
          default: cmd.code = sdnft_pkg::DISP_RULE_DROP;
        endcase
      end
      sdnft_pkg::S_PK_CHECK: begin
        if (st.park_full) begin
          cmd.emit = 1'b1;
          cmd.code = sdnft_pkg::DISP_PARK_FULL;
        end else begin
          cmd.op = sdnft_pkg::OP_K_INIT;
        end
      end
      sdnft_pkg::S_PK_SCAN: begin
        if (st.k_end) begin
          cmd.op   = sdnft_pkg::OP_PK_PUSH;
          cmd.emit = 1'b1;
          cmd.code = sdnft_pkg::DISP_PACKET_IN;
        end else if (st.k_hit) begin
          cmd.op   = sdnft_pkg::OP_PK_PUSH;
          cmd.emit = 1'b1;
          cmd.code = sdnft_pkg::DISP_PARKED;
        end else begin
          cmd.op = sdnft_pkg::OP_K_NEXT;
        end
      end
      sdnft_pkg::S_INS_CHECK: begin
        if (st.table_full) begin
          cmd.emit = 1'b1;
          cmd.code = sdnft_pkg::DISP_TABLE_FULL;
          cmd.last = 1'b1;
        end else begin
          cmd.op = sdnft_pkg::OP_R_INIT;
        end
      end
      sdnft_pkg::S_INS_SCAN: cmd.op = sdnft_pkg::OP_INS_STEP;
      sdnft_pkg::S_INS_WRITE: cmd.op = sdnft_pkg::OP_INS_WRITE;
      sdnft_pkg::S_CMP: begin
        if (st.k_end) begin
          cmd.op   = sdnft_pkg::OP_CMP_END;
          cmd.emit = 1'b1;
          cmd.code = sdnft_pkg::DISP_INSTALLED;
          cmd.last = st.sel_empty;
        end else begin
          cmd.op = sdnft_pkg::OP_CMP_STEP;
        end
      end
      sdnft_pkg::S_RP_LOAD: cmd.op = sdnft_pkg::OP_RP_LOAD;
      sdnft_pkg::S_BC_SCAN: begin
        cmd.last = 1'b1;
        if (st.n_end) begin
          cmd.emit = 1'b1;
          if (st.nbr_full) begin
            cmd.code = sdnft_pkg::DISP_NBR_KNOWN;
          end else begin
            cmd.op   = sdnft_pkg::OP_NBR_ADD;
            cmd.code = sdnft_pkg::DISP_NBR_ADDED;
          end
        end else if (st.n_hit_src) begin
          cmd.emit = 1'b1;
          cmd.code = sdnft_pkg::DISP_NBR_KNOWN;
        end else begin
          cmd.op = sdnft_pkg::OP_N_NEXT;
        end
      end
      default: cmd.op = sdnft_pkg::OP_NONE;
    endcase
  end

endmodule

// ----- design/sdnft_dp.sv -----
// sdnft_dp: storage and compare datapath of the flow-table switch
// flow table, neighbor set, park buffer, replay list, standby fifo, result register
// depends on sdnft_pkg; driven by sdnft_ctrl commands
module sdnft_dp #(
  parameter int FLOW_DEPTH    = 16,
  parameter int NBR_DEPTH     = 32,
  parameter int PARK_DEPTH    = 16,
  parameter int STANDBY_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  sdnft_pkg::cfg_t     cfg,
  input  sdnft_pkg::item_t    item_in,
  input  sdnft_pkg::cmd_t     cmd,
  output sdnft_pkg::status_t  st,
  output logic                res_valid,
  output sdnft_pkg::result_t  res
);

  localparam int RIW = (FLOW_DEPTH > 1) ? $clog2(FLOW_DEPTH) : 1;
  localparam int RCW = $clog2(FLOW_DEPTH + 1);
  localparam int NIW = (NBR_DEPTH > 1) ? $clog2(NBR_DEPTH) : 1;
  localparam int NCW = $clog2(NBR_DEPTH + 1);
  localparam int PIW = (PARK_DEPTH > 1) ? $clog2(PARK_DEPTH) : 1;
  localparam int PCW = $clog2(PARK_DEPTH + 1);
  localparam int SIW = (STANDBY_DEPTH > 1) ? $clog2(STANDBY_DEPTH) : 1;
  localparam int SCW = $clog2(STANDBY_DEPTH + 1);
  localparam int SSW = SCW + 1;

  sdnft_pkg::item_t item;
  sdnft_pkg::pkt_t  p;

  logic [FLOW_DEPTH-1:0] rule_valid;
  logic [15:0] rule_dest [FLOW_DEPTH];
  logic [1:0]  rule_act [FLOW_DEPTH];
  logic [15:0] rule_hop [FLOW_DEPTH];
  logic [31:0] rule_install_time [FLOW_DEPTH];
  logic [31:0] rule_last_use [FLOW_DEPTH];
  logic [31:0] rule_idle_limit [FLOW_DEPTH];
  logic [31:0] rule_hard_limit [FLOW_DEPTH];
  logic [15:0] nbr_addr [NBR_DEPTH];
  sdnft_pkg::pkt_t park_entry [PARK_DEPTH];
  sdnft_pkg::pkt_t sel_entry [PARK_DEPTH];
  sdnft_pkg::pkt_t standby_entry [STANDBY_DEPTH];

  logic [RIW-1:0] r, free_idx;
  logic [RCW-1:0] used;
  logic           free_found;
  logic [NCW-1:0] n, nbr_count;
  logic [PCW-1:0] k, keep, park_count, sel_count, si;
  logic [SIW-1:0] sb_head;
  logic [SCW-1:0] sb_count;

  logic [32:0] hard_sum, idle_sum, now_x;
  logic        ins_hit, ins_free;
  logic [SSW-1:0] tail_sum, tail_wrap;
  logic [SIW-1:0] sb_tail, sb_head_inc;
  logic [RIW-1:0] r_inc;
  logic        fwd_code;

  assign now_x    = {1'b0, item.time_now};
  assign hard_sum = {1'b0, rule_install_time[r]} + {1'b0, rule_hard_limit[r]};
  assign idle_sum = {1'b0, rule_last_use[r]} + {1'b0, rule_idle_limit[r]};
  assign ins_hit  = rule_valid[r] && (rule_dest[r] == p.dst);
  assign ins_free = !rule_valid[r] || ins_hit;
  assign r_inc    = st.r_last ? '0 : r + 1'b1;

  assign tail_sum    = SSW'(sb_head) + SSW'(sb_count);
  assign tail_wrap   = (tail_sum >= SSW'(STANDBY_DEPTH)) ?
                       tail_sum - SSW'(STANDBY_DEPTH) : tail_sum;
  assign sb_tail     = tail_wrap[SIW-1:0];
  assign sb_head_inc = (sb_head == SIW'(STANDBY_DEPTH - 1)) ? '0 : sb_head + 1'b1;

  always_comb begin
    st.req_type   = item.req_type;
    st.r_act      = rule_act[r];
    st.recip_me   = (item.recipient_addr == cfg.my_id);
    st.owner_me   = (item.rule_owner == cfg.my_id);
    st.dst_me     = (p.dst == cfg.my_id);
    st.src_me     = (p.src == cfg.my_id);
    st.ttl_zero   = (p.ttl == 8'd0);
    st.r_valid    = rule_valid[r];
    st.r_expired  = (now_x > hard_sum) || (now_x > idle_sum);
    st.r_dest_hit = (rule_dest[r] == p.dst);
    st.r_wired    = !cfg.is_vehicle && (rule_hop[r] >= cfg.rsu_prefix);
    st.r_last     = (r == RIW'(FLOW_DEPTH - 1));
    st.n_end      = (n >= nbr_count);
    st.n_hit_hop  = (nbr_addr[n[NIW-1:0]] == rule_hop[r]);
    st.n_hit_src  = (nbr_addr[n[NIW-1:0]] == p.src);
    st.nbr_full   = (nbr_count >= NCW'(NBR_DEPTH));
    st.table_full = (used >= RCW'(FLOW_DEPTH)) ||
                    (32'(used) >= 32'(cfg.max_flow_rules));
    st.park_full  = (park_count >= PCW'(PARK_DEPTH)) ||
                    (32'(park_count) >= 32'(cfg.max_packet_in));
    st.k_end      = (k >= park_count);
    st.k_hit      = (park_entry[k[PIW-1:0]].dst == p.dst);
    st.sb_full    = (sb_count >= SCW'(STANDBY_DEPTH)) ||
                    (32'(sb_count) >= 32'(cfg.max_standby));
    st.sb_empty   = (sb_count == '0);
    st.sel_empty  = (sel_count == '0);
    st.sel_done   = (si == sel_count);
  end

  assign fwd_code = (cmd.code == sdnft_pkg::DISP_RADIO_FWD) ||
                    (cmd.code == sdnft_pkg::DISP_WIRED_FWD);

  // control state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_valid <= '0;
      nbr_count  <= '0;
      park_count <= '0;
      sb_head    <= '0;
      sb_count   <= '0;
      res_valid  <= 1'b0;
    end else begin
      res_valid <= cmd.emit;
      unique case (cmd.op)
        sdnft_pkg::OP_R_KILL: rule_valid[r] <= 1'b0;
        sdnft_pkg::OP_INS_STEP: begin
          if (ins_hit) rule_valid[r] <= 1'b0;
        end
        sdnft_pkg::OP_INS_WRITE: begin
          if (free_found) rule_valid[free_idx] <= 1'b1;
        end
        sdnft_pkg::OP_SB_PUSH: sb_count <= sb_count + 1'b1;
        sdnft_pkg::OP_SB_POP: begin
          sb_head  <= sb_head_inc;
          sb_count <= sb_count - 1'b1;
        end
        sdnft_pkg::OP_PK_PUSH: park_count <= park_count + 1'b1;
        sdnft_pkg::OP_CMP_END: park_count <= keep;
        sdnft_pkg::OP_NBR_ADD: nbr_count <= nbr_count + 1'b1;
        sdnft_pkg::OP_NBR_CLR: nbr_count <= '0;
        default: ;
      endcase
    end
  end

  // storage and working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      sdnft_pkg::OP_LOAD: begin
        item <= item_in;
        p    <= '{handle: item_in.packet_handle, src: item_in.src_addr,
                  dst: item_in.dst_addr, ttl: item_in.ttl};
      end
      sdnft_pkg::OP_R_INIT: begin
        r          <= '0;
        used       <= '0;
        free_found <= 1'b0;
      end
      sdnft_pkg::OP_R_NEXT, sdnft_pkg::OP_R_KILL: r <= r_inc;
      sdnft_pkg::OP_R_KEEP: begin
        used <= used + 1'b1;
        r    <= r_inc;
      end
      sdnft_pkg::OP_N_INIT: n <= '0;
      sdnft_pkg::OP_N_NEXT: n <= n + 1'b1;
      sdnft_pkg::OP_HIT: rule_last_use[r] <= item.time_now;
      sdnft_pkg::OP_SB_PUSH: standby_entry[sb_tail] <= p;
      sdnft_pkg::OP_SB_POP: p <= standby_entry[sb_head];
      sdnft_pkg::OP_K_INIT: k <= '0;
      sdnft_pkg::OP_K_NEXT: k <= k + 1'b1;
      sdnft_pkg::OP_PK_PUSH: park_entry[park_count[PIW-1:0]] <= p;
      sdnft_pkg::OP_INS_STEP: begin
        if (ins_free && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= r;
        end
        r <= r_inc;
      end
      sdnft_pkg::OP_INS_WRITE: begin
        rule_dest[free_idx]         <= p.dst;
        rule_act[free_idx]          <= item.rule_action;
        rule_hop[free_idx]          <= item.rule_next_hop;
        rule_idle_limit[free_idx]   <= item.rule_idle_timeout;
        rule_hard_limit[free_idx]   <= item.rule_hard_timeout;
        rule_install_time[free_idx] <= item.time_now;
        rule_last_use[free_idx]     <= item.time_now;
        k         <= '0;
        keep      <= '0;
        sel_count <= '0;
      end
      sdnft_pkg::OP_CMP_STEP: begin
        if (st.k_hit) begin
          sel_entry[sel_count[PIW-1:0]] <= park_entry[k[PIW-1:0]];
          sel_count <= sel_count + 1'b1;
        end else begin
          park_entry[keep[PIW-1:0]] <= park_entry[k[PIW-1:0]];
          keep <= keep + 1'b1;
        end
        k <= k + 1'b1;
      end
      sdnft_pkg::OP_CMP_END: si <= '0;
      sdnft_pkg::OP_RP_LOAD: begin
        p  <= sel_entry[si[PIW-1:0]];
        si <= si + 1'b1;
      end
      sdnft_pkg::OP_NBR_ADD: nbr_addr[nbr_count[NIW-1:0]] <= p.src;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res.disposition  <= cmd.code;
      res.out_handle   <= (cmd.code >= sdnft_pkg::DISP_DELIVER &&
                           cmd.code <= sdnft_pkg::DISP_PARK_FULL) ? p.handle : 16'd0;
      res.out_next_hop <= fwd_code ? rule_hop[r] : 16'd0;
      res.out_ttl      <= fwd_code ? p.ttl - 8'd1 : 8'd0;
      res.out_dst      <= (cmd.code == sdnft_pkg::DISP_PACKET_IN) ? p.dst : 16'd0;
      res.last         <= cmd.last;
    end
  end

endmodule

// ----- design/sdn_flow_table_switch_unit.sv -----
// sdn_flow_table_switch_unit: top level of the flow-table switch
// apb register file, sequencer sdnft_ctrl and datapath sdnft_dp
// depends on sdnft_pkg
//
//  channel   signals                           beat taken when
//  config    psel penable pwrite paddr pwdata  psel & penable & pwrite (pready high)
//  request   start req                         start & !busy
//  result    res_valid res                     res_valid, one cycle, last marks the end
//
// a data request runs dispatch, the cleanup sweep of the table (comparing the
// neighbor set for each live forward rule), the match scan and, on a miss, a scan
// of the parked packets that ends by parking it unless the park buffer is full;
// installs add a second table sweep, a park compaction and a full data pass per replay
// synchronous reset empties table, neighbor set, park buffer and standby fifo
// results cannot be stalled; busy drops at the edge that shows the beat with last
module sdn_flow_table_switch_unit #(
  parameter int FLOW_DEPTH    = 16,
  parameter int NBR_DEPTH     = 32,
  parameter int PARK_DEPTH    = 16,
  parameter int STANDBY_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sdnft_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             start,
  input  sdnft_pkg::item_t                 req,
  output logic                             busy,
  output logic                             res_valid,
  output sdnft_pkg::result_t               res
);

  sdnft_pkg::cfg_t    cfg;
  sdnft_pkg::cmd_t    cmd;
  sdnft_pkg::status_t st;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{my_id: 16'd0, rsu_prefix: 16'd1000, is_vehicle: 1'b1,
               max_flow_rules: 5'd16, max_packet_in: 5'd16, max_standby: 5'd16};
    end else if (wr_en) begin
      unique case (paddr[4:2])
        sdnft_pkg::REG_MY_ID:       cfg.my_id          <= pwdata[15:0];
        sdnft_pkg::REG_RSU_PREFIX:  cfg.rsu_prefix     <= pwdata[15:0];
        sdnft_pkg::REG_IS_VEHICLE:  cfg.is_vehicle     <= pwdata[0];
        sdnft_pkg::REG_MAX_FLOW:    cfg.max_flow_rules <= pwdata[4:0];
        sdnft_pkg::REG_MAX_PKT_IN:  cfg.max_packet_in  <= pwdata[4:0];
        sdnft_pkg::REG_MAX_STANDBY: cfg.max_standby    <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      sdnft_pkg::REG_MY_ID:       prdata = {16'd0, cfg.my_id};
      sdnft_pkg::REG_RSU_PREFIX:  prdata = {16'd0, cfg.rsu_prefix};
      sdnft_pkg::REG_IS_VEHICLE:  prdata = {31'd0, cfg.is_vehicle};
      sdnft_pkg::REG_MAX_FLOW:    prdata = {27'd0, cfg.max_flow_rules};
      sdnft_pkg::REG_MAX_PKT_IN:  prdata = {27'd0, cfg.max_packet_in};
      sdnft_pkg::REG_MAX_STANDBY: prdata = {27'd0, cfg.max_standby};
      default:                    prdata = 32'd0;
    endcase
  end

  sdnft_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .busy  (busy),
    .cmd   (cmd)
  );

  sdnft_dp #(
    .FLOW_DEPTH    (FLOW_DEPTH),
    .NBR_DEPTH     (NBR_DEPTH),
    .PARK_DEPTH    (PARK_DEPTH),
    .STANDBY_DEPTH (STANDBY_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item_in   (req),
    .cmd       (cmd),
    .st        (st),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

// ----- design/sdnft_chk.sv -----
// sdnft_chk: port-level checks for sdn_flow_table_switch_unit
// bound to the top level below
// depends on sdnft_pkg
module sdnft_chk (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               res_valid,
  input sdnft_pkg::result_t res
);

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_mid_beat_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last |-> busy)
    else $error("non-final beat while idle");

  a_end_with_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> res_valid && res.last)
    else $error("busy dropped without final beat");

  a_fwd_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.disposition != sdnft_pkg::DISP_RADIO_FWD &&
    res.disposition != sdnft_pkg::DISP_WIRED_FWD |->
    res.out_next_hop == 16'd0 && res.out_ttl == 8'd0)
    else $error("hop or ttl set on non-forward beat");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.disposition <= sdnft_pkg::DISP_STANDBY_EMPTY)
    else $error("disposition out of range");

endmodule

bind sdn_flow_table_switch_unit sdnft_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .res_valid (res_valid),
  .res       (res)
);

// ----- tb/sv/sdn_flow_table_switch_unit_tb.sv -----
// sdn_flow_table_switch_unit_tb: self-checking bench for the flow-table switch
// drives apb writes and request beats, predicts every result beat and checks it
// depends on sdnft_pkg and sdn_flow_table_switch_unit
`timescale 1ns / 100ps

module sdn_flow_table_switch_unit_tb;

  localparam int CYCLE_LIMIT = 12000000;
  localparam logic [2:0] REQ_SPARE = 3'd7;

  class flow_disposition_board;
    logic [15:0] my_id = 16'd0;
    logic [15:0] rsu_prefix = 16'd1000;
    logic        is_vehicle = 1'b1;
    logic [4:0]  max_flow = 5'd16, max_pkt_in = 5'd16, max_standby = 5'd16;

    bit          rule_on [16];
    logic [15:0] rule_key [16];
    logic [1:0]  rule_act [16];
    logic [15:0] rule_hop [16];
    logic [31:0] rule_born [16], rule_used [16], rule_idle [16], rule_hard [16];
    logic [15:0] nbr [32];
    int          nbr_count = 0;
    sdnft_pkg::pkt_t park [16];
    int          park_count = 0;
    sdnft_pkg::pkt_t sby [16];
    int          sby_head = 0, sby_count = 0;

    sdnft_pkg::result_t batch[$];
    sdnft_pkg::result_t expected_beats[$];
    int      errors = 0, checked = 0;

    function int clamp16(logic [4:0] v);
      return (v < 16) ? int'(v) : 16;
    endfunction

    function void push(sdnft_pkg::disp_t d, logic [15:0] h, logic [15:0] hop, logic [7:0] t,
                       logic [15:0] dst);
      sdnft_pkg::result_t r;
      r.disposition = d;
      r.out_handle = h;
      r.out_next_hop = hop;
      r.out_ttl = t;
      r.out_dst = dst;
      r.last = 1'b0;
      batch.insert(batch.size(), r);
    endfunction

    function bit is_nbr(logic [15:0] a);
      for (int i = 0; i < nbr_count; i++) if (nbr[i] == a) return 1;
      return 0;
    endfunction

    function void sweep(logic [31:0] now);
      logic [32:0] hard_end, idle_end;
      for (int i = 0; i < 16; i++) begin
        if (!rule_on[i]) continue;
        hard_end = {1'b0, rule_born[i]} + {1'b0, rule_hard[i]};
        idle_end = {1'b0, rule_used[i]} + {1'b0, rule_idle[i]};
        if ({1'b0, now} > hard_end) rule_on[i] = 0;
        else if ({1'b0, now} > idle_end) rule_on[i] = 0;
        else if (rule_act[i] == sdnft_pkg::ACT_FWD && !is_nbr(rule_hop[i])) rule_on[i] = 0;
      end
    endfunction

    function void route(sdnft_pkg::pkt_t p, logic [31:0] now);
      bit wired;
      sweep(now);
      if (p.dst == my_id) begin
        push(sdnft_pkg::DISP_DELIVER, p.handle, 0, 0, 0);
        return;
      end
      if (p.ttl == 0) begin
        push(sdnft_pkg::DISP_TTL_DROP, p.handle, 0, 0, 0);
        return;
      end
      for (int i = 0; i < 16; i++) begin
        if (!rule_on[i] || rule_key[i] != p.dst) continue;
        rule_used[i] = now;
        if (rule_act[i] == sdnft_pkg::ACT_SPECIAL && p.src != my_id) begin
          push(sdnft_pkg::DISP_SPECIAL_DROP, p.handle, 0, 0, 0);
        end else if (rule_act[i] == sdnft_pkg::ACT_FWD ||
                     rule_act[i] == sdnft_pkg::ACT_SPECIAL) begin
          wired = !is_vehicle && rule_hop[i] >= rsu_prefix;
          push(wired ? sdnft_pkg::DISP_WIRED_FWD : sdnft_pkg::DISP_RADIO_FWD, p.handle,
               rule_hop[i], p.ttl - 8'd1, 0);
        end else if (rule_act[i] == sdnft_pkg::ACT_STANDBY) begin
          if (sby_count >= clamp16(max_standby)) begin
            push(sdnft_pkg::DISP_STANDBY_FULL, p.handle, 0, 0, 0);
          end else begin
            sby[(sby_head + sby_count) % 16] = p;
            sby_count++;
            push(sdnft_pkg::DISP_STANDBY, p.handle, 0, 0, 0);
          end
        end else begin
          push(sdnft_pkg::DISP_RULE_DROP, p.handle, 0, 0, 0);
        end
        return;
      end
      if (park_count >= clamp16(max_pkt_in)) begin
        push(sdnft_pkg::DISP_PARK_FULL, p.handle, 0, 0, 0);
        return;
      end
      for (int k = 0; k < park_count; k++) begin
        if (park[k].dst == p.dst) begin
          park[park_count++] = p;
          push(sdnft_pkg::DISP_PARKED, p.handle, 0, 0, 0);
          return;
        end
      end
      park[park_count++] = p;
      push(sdnft_pkg::DISP_PACKET_IN, p.handle, 0, 0, p.dst);
    endfunction

    function void configure(logic [2:0] idx, logic [31:0] v);
      case (idx)
        sdnft_pkg::REG_MY_ID:       my_id = v[15:0];
        sdnft_pkg::REG_RSU_PREFIX:  rsu_prefix = v[15:0];
        sdnft_pkg::REG_IS_VEHICLE:  is_vehicle = v[0];
        sdnft_pkg::REG_MAX_FLOW:    max_flow = v[4:0];
        sdnft_pkg::REG_MAX_PKT_IN:  max_pkt_in = v[4:0];
        sdnft_pkg::REG_MAX_STANDBY: max_standby = v[4:0];
        default: ;
      endcase
    endfunction

    function void note_item(sdnft_pkg::item_t it);
      sdnft_pkg::pkt_t p, q;
      sdnft_pkg::pkt_t picked[$];
      int used, slot, keep;
      p.handle = it.packet_handle;
      p.src = it.src_addr;
      p.dst = it.dst_addr;
      p.ttl = it.ttl;
      batch.delete();
      case (it.req_type)
        sdnft_pkg::REQ_DATA: begin
          if (it.recipient_addr != my_id) push(sdnft_pkg::DISP_IGNORED, 0, 0, 0, 0);
          else route(p, it.time_now);
        end
        sdnft_pkg::REQ_INSTALL: begin
          if (it.rule_owner != my_id) begin
            push(sdnft_pkg::DISP_IGNORED, 0, 0, 0, 0);
          end else begin
            sweep(it.time_now);
            used = 0;
            for (int i = 0; i < 16; i++) if (rule_on[i]) used++;
            if (used >= clamp16(max_flow)) begin
              push(sdnft_pkg::DISP_TABLE_FULL, 0, 0, 0, 0);
            end else begin
              for (int i = 0; i < 16; i++)
                if (rule_on[i] && rule_key[i] == p.dst) rule_on[i] = 0;
              slot = -1;
              for (int i = 0; i < 16 && slot < 0; i++) if (!rule_on[i]) slot = i;
              if (slot >= 0) begin
                rule_on[slot] = 1;
                rule_key[slot] = p.dst;
                rule_act[slot] = it.rule_action;
                rule_hop[slot] = it.rule_next_hop;
                rule_idle[slot] = it.rule_idle_timeout;
                rule_hard[slot] = it.rule_hard_timeout;
                rule_born[slot] = it.time_now;
                rule_used[slot] = it.time_now;
              end
              push(sdnft_pkg::DISP_INSTALLED, 0, 0, 0, 0);
              keep = 0;
              for (int k = 0; k < park_count; k++) begin
                if (park[k].dst == p.dst) picked.insert(picked.size(), park[k]);
                else park[keep++] = park[k];
              end
              park_count = keep;
              foreach (picked[k]) route(picked[k], it.time_now);
            end
          end
        end
        sdnft_pkg::REQ_BEACON: begin
          if (is_nbr(p.src) || nbr_count >= 32) begin
            push(sdnft_pkg::DISP_NBR_KNOWN, 0, 0, 0, 0);
          end else begin
            nbr[nbr_count++] = p.src;
            push(sdnft_pkg::DISP_NBR_ADDED, 0, 0, 0, 0);
          end
        end
        sdnft_pkg::REQ_CLEAR: begin
          nbr_count = 0;
          push(sdnft_pkg::DISP_CLEARED, 0, 0, 0, 0);
        end
        sdnft_pkg::REQ_RELEASE: begin
          if (sby_count == 0) begin
            push(sdnft_pkg::DISP_STANDBY_EMPTY, 0, 0, 0, 0);
          end else begin
            q = sby[sby_head];
            sby_head = (sby_head + 1) % 16;
            sby_count--;
            route(q, it.time_now);
          end
        end
        default: push(sdnft_pkg::DISP_IGNORED, 0, 0, 0, 0);
      endcase
      batch[batch.size() - 1].last = 1'b1;
      foreach (batch[k]) expected_beats.insert(expected_beats.size(), batch[k]);
    endfunction

    function void check_result(sdnft_pkg::result_t got);
      sdnft_pkg::result_t exp;
      checked++;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      exp = expected_beats.pop_front();
      if (got.disposition !== exp.disposition) begin
        $display("%0t: disposition exp %0d got %0d", $time, exp.disposition, got.disposition);
        errors++;
      end
      if (got.out_handle !== exp.out_handle) begin
        $display("%0t: out_handle exp %h got %h", $time, exp.out_handle, got.out_handle);
        errors++;
      end
      if (got.out_next_hop !== exp.out_next_hop) begin
        $display("%0t: out_next_hop exp %h got %h", $time, exp.out_next_hop,
                 got.out_next_hop);
        errors++;
      end
      if (got.out_ttl !== exp.out_ttl) begin
        $display("%0t: out_ttl exp %h got %h", $time, exp.out_ttl, got.out_ttl);
        errors++;
      end
      if (got.out_dst !== exp.out_dst) begin
        $display("%0t: out_dst exp %h got %h", $time, exp.out_dst, got.out_dst);
        errors++;
      end
      if (got.last !== exp.last) begin
        $display("%0t: last exp %b got %b", $time, exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [sdnft_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  sdnft_pkg::item_t   req = '0;
  logic        busy, res_valid;
  sdnft_pkg::result_t res;

  flow_disposition_board board = new();
  int          cycles = 0;
  int          burst_left = 0;
  int          items_sent = 0;
  logic [31:0] tnow = 32'd0;
  logic [15:0] cur_id = 16'd0;

  sdn_flow_table_switch_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .req(req), .busy(busy),
    .res_valid(res_valid), .res(res)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sdn_flow_table_switch_unit_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid) board.check_result(res);
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= sdnft_pkg::ADDR_W'(idx) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.configure(idx, v);
    if (idx == sdnft_pkg::REG_MY_ID) cur_id = v[15:0];
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.expected_beats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send(sdnft_pkg::item_t it);
    start <= 1'b1;
    req <= it;
    do @(posedge clk); while (busy);
    board.note_item(it);
    items_sent++;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = $urandom_range(0, 14);
    end else begin
      burst_left--;
    end
  endtask

  function automatic sdnft_pkg::item_t data_item(logic [15:0] src, logic [15:0] dst,
                                                 logic [7:0] ttl);
    sdnft_pkg::item_t it;
    it = '0;
    it.req_type = sdnft_pkg::REQ_DATA;
    it.time_now = tnow;
    it.recipient_addr = cur_id;
    it.src_addr = src;
    it.dst_addr = dst;
    it.ttl = ttl;
    it.packet_handle = 16'($urandom);
    return it;
  endfunction

  function automatic sdnft_pkg::item_t rule_item(logic [15:0] dst, logic [1:0] act,
                                                 logic [15:0] hop, logic [31:0] idle,
                                                 logic [31:0] hard);
    sdnft_pkg::item_t it;
    it = '0;
    it.req_type = sdnft_pkg::REQ_INSTALL;
    it.time_now = tnow;
    it.dst_addr = dst;
    it.rule_action = act;
    it.rule_next_hop = hop;
    it.rule_idle_timeout = idle;
    it.rule_hard_timeout = hard;
    it.rule_owner = cur_id;
    return it;
  endfunction

  function automatic sdnft_pkg::item_t ctl_item(logic [2:0] kind, logic [15:0] src);
    sdnft_pkg::item_t it;
    it = '0;
    it.req_type = kind;
    it.time_now = tnow;
    it.src_addr = src;
    return it;
  endfunction

  function automatic logic [15:0] pick_addr(bit with_me);
    case ($urandom_range(0, 6))
      0: return 16'd10;
      1: return 16'd11;
      2: return 16'd1000;
      3: return 16'd1001;
      4: return with_me ? cur_id : 16'd12;
      5: return 16'd12;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sdnft_pkg::item_t random_item();
    sdnft_pkg::item_t it;
    int r;
    logic [223:0] raw;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      it = ctl_item(sdnft_pkg::REQ_BEACON, pick_addr(0));
    end else if (r < 11) begin
      it = ctl_item(sdnft_pkg::REQ_CLEAR, 16'($urandom));
    end else if (r < 30) begin
      it = rule_item(pick_addr(1), 2'($urandom), pick_addr(0),
                     ($urandom_range(0, 99) < 15) ? $urandom : $urandom_range(0, 120),
                     ($urandom_range(0, 99) < 15) ? $urandom : $urandom_range(20, 400));
      if ($urandom_range(0, 9) == 0) it.rule_owner = 16'($urandom);
    end else if (r < 40) begin
      it = ctl_item(sdnft_pkg::REQ_RELEASE, 16'($urandom));
    end else if (r < 46) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      it = raw[$bits(sdnft_pkg::item_t)-1:0];
    end else begin
      it = data_item(($urandom_range(0, 2) == 0) ? cur_id : pick_addr(0), pick_addr(1),
                     ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom));
      if ($urandom_range(0, 9) == 0) it.recipient_addr = 16'($urandom);
      if ($urandom_range(0, 9) == 0) it.ttl = 8'd1;
    end
    return it;
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) begin
      tnow = tnow + $urandom_range(0, 15);
      send(random_item());
    end
  endtask

  task automatic set_regs(logic [15:0] id, logic [15:0] rsu, logic veh,
                          logic [4:0] mf, logic [4:0] mp, logic [4:0] ms);
    reg_write(sdnft_pkg::REG_MY_ID, {16'h0, id});
    reg_write(sdnft_pkg::REG_RSU_PREFIX, {16'h0, rsu});
    reg_write(sdnft_pkg::REG_IS_VEHICLE, {31'h0, veh});
    reg_write(sdnft_pkg::REG_MAX_FLOW, {27'h0, mf});
    reg_write(sdnft_pkg::REG_MAX_PKT_IN, {27'h0, mp});
    reg_write(sdnft_pkg::REG_MAX_STANDBY, {27'h0, ms});
  endtask

  initial begin
    sdnft_pkg::item_t it;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // default limits, long park chain replayed by one install
    set_regs(16'd5, 16'd1000, 1'b1, 5'd16, 5'd16, 5'd16);
    send(ctl_item(sdnft_pkg::REQ_BEACON, 16'd10));
    send(ctl_item(sdnft_pkg::REQ_BEACON, 16'd10));
    it = data_item(16'd9, 16'd30, 8'd3);
    it.recipient_addr = 16'd6;
    send(it);
    send(data_item(16'd9, 16'd5, 8'd9));
    send(data_item(16'd9, 16'd30, 8'd0));
    for (int i = 0; i < 17; i++) send(data_item(16'd9, 16'd30, (i == 0) ? 8'd255 : 8'd1));
    send(rule_item(16'd30, sdnft_pkg::ACT_FWD, 16'd10, 32'hffff_ffff, 32'hffff_ffff));
    random_run(50);
    drain();

    // roadside unit, tight limits, special drop and standby
    set_regs(16'd7, 16'd1000, 1'b0, 5'd2, 5'd3, 5'd1);
    send(ctl_item(sdnft_pkg::REQ_BEACON, 16'd1001));
    send(rule_item(16'd40, sdnft_pkg::ACT_SPECIAL, 16'd1001, 32'd500, 32'd500));
    send(data_item(16'd7, 16'd40, 8'd8));
    send(data_item(16'd9, 16'd40, 8'd8));
    send(rule_item(16'd41, sdnft_pkg::ACT_STANDBY, 16'd0, 32'd500, 32'd500));
    send(rule_item(16'd42, sdnft_pkg::ACT_DROP, 16'd0, 32'd500, 32'd500));
    send(data_item(16'd9, 16'd41, 8'd8));
    send(data_item(16'd9, 16'd41, 8'd8));
    send(ctl_item(sdnft_pkg::REQ_RELEASE, 16'd0));
    send(ctl_item(sdnft_pkg::REQ_RELEASE, 16'd0));
    send(ctl_item(REQ_SPARE, 16'd0));
    send(ctl_item(sdnft_pkg::REQ_CLEAR, 16'd0));
    random_run(50);
    drain();

    // top of the address and time ranges, oversized limits
    set_regs(16'hffff, 16'd0, 1'b1, 5'd31, 5'd31, 5'd31);
    tnow = 32'hffff_fff0;
    send(ctl_item(sdnft_pkg::REQ_BEACON, 16'd11));
    send(rule_item(16'd50, sdnft_pkg::ACT_DROP, 16'd11, 32'hffff_ffff, 32'hffff_ffff));
    tnow = 32'hffff_ffff;
    send(data_item(16'hffff, 16'd50, 8'd255));
    send(rule_item(16'd51, sdnft_pkg::ACT_DROP, 16'd11, 32'd0, 32'd0));
    send(data_item(16'd1, 16'd51, 8'd2));
    tnow = 32'd0;
    random_run(50);
    drain();

    // zero limits: no rule, parked packet or standby entry fits
    set_regs(16'd0, 16'hffff, 1'b0, 5'd0, 5'd0, 5'd0);
    send(rule_item(16'd60, sdnft_pkg::ACT_FWD, 16'd10, 32'd100, 32'd100));
    send(data_item(16'd3, 16'd60, 8'd4));
    random_run(40);
    drain();

    $display("covered %0d request beats and %0d result beats over four register settings",
             items_sent, board.checked);
    if (board.errors == 0 && board.expected_beats.size() == 0) begin
      $display("sdn_flow_table_switch_unit_tb: done, clean");
    end else begin
      $display("%0d mismatches, %0d beats never seen", board.errors,
               board.expected_beats.size());
      $display("sdn_flow_table_switch_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
